### rtl/ata_pio_taskfile_builder_top_defines.svh
// Assertion helpers for the task-file builder.
`ifndef ATA_PIO_TASKFILE_BUILDER_TOP_DEFINES_SVH
`define ATA_PIO_TASKFILE_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define ATB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("task-file builder check failed");

// Next-cycle implication, quiet during reset.
`define ATB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("task-file builder check failed");

`endif

### rtl/atb_pkg.sv
package atb_pkg;

  localparam int MaxWrites = 10;

  // Task-file register offsets
  localparam logic [2:0] REG_COUNT = 3'd2;
  localparam logic [2:0] REG_LBA0  = 3'd3;
  localparam logic [2:0] REG_LBA1  = 3'd4;
  localparam logic [2:0] REG_LBA2  = 3'd5;
  localparam logic [2:0] REG_DSEL  = 3'd6;
  localparam logic [2:0] REG_CMD   = 3'd7;

  // Command bytes
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

  // Drive select bits
  localparam logic [7:0] DSEL_BASE  = 8'hA0;
  localparam logic [7:0] DSEL_LBA   = 8'h40;
  localparam logic [7:0] DSEL_SLAVE = 8'h10;

  localparam logic [7:0] MAX_COUNT = 8'd255;

  // Division by 63 sectors per track: q = (a * RECIP) >> RECIP_SHIFT is exact or one low
  localparam int         RECIP_SHIFT = 34;
  localparam logic [28:0] RECIP      = 29'((64'd1 << RECIP_SHIFT) / 64'd63);
  localparam logic [6:0] CHS_SECTORS = 7'd63;

  // Configuration register indexes
  localparam logic CFG_LBA_SUPPORTED = 1'b0;
  localparam logic CFG_SLAVE_DRIVE   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [47:0] block_address;
    logic [31:0] buffer_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0] reg_offset;
    logic [7:0] reg_value;
    logic       last_write;
  } wr_t;

  typedef wr_t [MaxWrites-1:0] plan_t;

  function automatic wr_t mk_wr(logic [2:0] off, logic [7:0] val, logic last);
    wr_t w;
    w.reg_offset = off;
    w.reg_value  = val;
    w.last_write = last;
    return w;
  endfunction

endpackage

### rtl/ata_pio_taskfile_builder_top.sv
// ATA PIO task-file builder. Each request transaction (direction, 48-bit block
// address, buffer length) becomes a stream of task-file register writes on the
// output channel: six for LBA28/CHS addresses, ten for LBA48 ones, one per cycle
// while out_ready holds, the final command write flagged by last_write. A request
// passes the registered input stage and then the multiply stage, the plan being
// built from the second, and then occupies the write sequencer until its command
// write is taken. The sequencer sets the sustained rate, taking the next plan in
// the same cycle the previous command write is taken, so requests stream with no
// gap. The CHS split divides by 63 through a registered reciprocal multiply.
// Registers: offset 0 lba_supported, offset 4 slave_drive (bit 0, reset 0);
// write them only while no request is in flight.
`include "ata_pio_taskfile_builder_top_defines.svh"

module ata_pio_taskfile_builder_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_ready,
  input  atb_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output atb_pkg::wr_t  out_data
);
  import atb_pkg::*;

  logic  lba_supported;
  logic  slave_drive;
  logic  plan_valid;
  logic  plan_ready;
  plan_t plan;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lba_supported <= 1'b0;
      slave_drive   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        CFG_LBA_SUPPORTED: lba_supported <= pwdata[0];
        CFG_SLAVE_DRIVE:   slave_drive   <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign prdata = {31'b0, (paddr[2] == CFG_SLAVE_DRIVE) ? slave_drive : lba_supported};

  atb_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .lba_supported(lba_supported),
    .slave_drive  (slave_drive),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .plan_valid   (plan_valid),
    .plan_ready   (plan_ready),
    .plan         (plan)
  );

  atb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .plan_valid(plan_valid),
    .plan_ready(plan_ready),
    .plan      (plan),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the command write is the only one that closes a sequence
  `ATB_ASSERT_SAME(a_last_is_cmd, clk, rst, out_valid && out_data.last_write, out_data.reg_offset == REG_CMD)
  // drive select always carries the fixed obsolete bits
  `ATB_ASSERT_SAME(a_dsel_base, clk, rst, out_valid && out_data.reg_offset == REG_DSEL, out_data.reg_value[7] && out_data.reg_value[5])
  // a sequence streams without a hole until its command write
  `ATB_ASSERT_NEXT(a_no_gap, clk, rst, out_valid && out_ready && !out_data.last_write, out_valid)

endmodule

### rtl/atb_decode.sv
module atb_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          lba_supported,
  input  logic          slave_drive,
  input  logic          in_valid,
  output logic          in_ready,
  input  atb_pkg::req_t in_data,
  output logic          plan_valid,
  input  logic          plan_ready,
  output atb_pkg::plan_t plan
);
  import atb_pkg::*;

  logic        s1_valid;
  req_t        s1_req;
  logic        s2_valid;
  req_t        s2_req;
  logic [56:0] s2_prod;
  logic        s1_ready;
  logic        s2_ready;

  logic        wide;
  logic        chs;
  logic [22:0] q0;
  logic [27:0] q63;
  logic [27:0] rem0;
  logic        fix;
  logic [22:0] track;
  logic [6:0]  sec;
  logic [7:0]  count;
  logic [3:0]  head;
  logic [7:0]  dsel;
  logic [7:0]  ab0, ab1, ab2;
  logic [7:0]  cmd;

  assign s2_ready = !s2_valid || plan_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
    if (s1_ready && in_valid) s1_req <= in_data;
    if (s2_ready && s1_valid) begin
      s2_req  <= s1_req;
      s2_prod <= 57'(s1_req.block_address[27:0] * RECIP);
    end
  end

  always_comb begin
    wide = |s2_req.block_address[47:28];
    chs  = !wide && !lba_supported;

    // correct the reciprocal estimate once
    q0   = s2_prod[56:RECIP_SHIFT];
    q63  = 28'({q0, 6'b0} - {6'b0, q0});
    rem0 = s2_req.block_address[27:0] - q63;
    fix  = rem0[6:0] >= CHS_SECTORS;
    track = fix ? q0 + 23'd1 : q0;
    sec   = fix ? rem0[6:0] - CHS_SECTORS : rem0[6:0];

    count = (|s2_req.buffer_bytes[31:17]) ? MAX_COUNT : s2_req.buffer_bytes[16:9];

    if (wide) begin
      head = 4'd0;
    end else if (chs) begin
      head = track[3:0];
    end else begin
      head = s2_req.block_address[27:24];
    end

    if (chs) begin
      ab0 = {1'b0, sec} + 8'd1;
      ab1 = track[11:4];
      ab2 = track[19:12];
    end else begin
      ab0 = s2_req.block_address[7:0];
      ab1 = s2_req.block_address[15:8];
      ab2 = s2_req.block_address[23:16];
    end

    dsel = DSEL_BASE | (chs ? 8'h00 : DSEL_LBA) | (slave_drive ? DSEL_SLAVE : 8'h00)
         | {4'b0, head};

    if (s2_req.op) cmd = wide ? CMD_WRITE_EXT : CMD_WRITE;
    else           cmd = wide ? CMD_READ_EXT : CMD_READ;

    plan    = '0;
    plan[0] = mk_wr(REG_DSEL, dsel, 1'b0);
    if (wide) begin
      plan[1] = mk_wr(REG_COUNT, 8'd0, 1'b0);
      plan[2] = mk_wr(REG_LBA0, s2_req.block_address[31:24], 1'b0);
      plan[3] = mk_wr(REG_LBA1, s2_req.block_address[39:32], 1'b0);
      plan[4] = mk_wr(REG_LBA2, s2_req.block_address[47:40], 1'b0);
      plan[5] = mk_wr(REG_COUNT, count, 1'b0);
      plan[6] = mk_wr(REG_LBA0, ab0, 1'b0);
      plan[7] = mk_wr(REG_LBA1, ab1, 1'b0);
      plan[8] = mk_wr(REG_LBA2, ab2, 1'b0);
      plan[9] = mk_wr(REG_CMD, cmd, 1'b1);
    end else begin
      plan[1] = mk_wr(REG_COUNT, count, 1'b0);
      plan[2] = mk_wr(REG_LBA0, ab0, 1'b0);
      plan[3] = mk_wr(REG_LBA1, ab1, 1'b0);
      plan[4] = mk_wr(REG_LBA2, ab2, 1'b0);
      plan[5] = mk_wr(REG_CMD, cmd, 1'b1);
    end
  end

  assign plan_valid = s2_valid;

endmodule

### rtl/atb_emit.sv
module atb_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           plan_valid,
  output logic           plan_ready,
  input  atb_pkg::plan_t plan,
  output logic           out_valid,
  input  logic           out_ready,
  output atb_pkg::wr_t   out_data
);
  import atb_pkg::*;

  plan_t      held;
  logic       busy;
  logic [3:0] idx;
  logic       done;

  assign out_valid  = busy;
  assign out_data   = held[idx];
  assign done       = out_ready && out_data.last_write;
  assign plan_ready = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (plan_ready) begin
      busy <= plan_valid;
      idx  <= 4'd0;
    end else if (out_ready) begin
      idx <= idx + 4'd1;
    end
    if (plan_ready && plan_valid) held <= plan;
  end

endmodule

### tb/sv/ata_pio_taskfile_builder_checker.sv
`timescale 1ns / 100ps

module ata_pio_taskfile_builder_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  input  logic          in_valid,
  input  logic          in_ready,
  input  atb_pkg::req_t in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  atb_pkg::wr_t  out_data,
  output int            errors,
  output int            pending_writes,
  output int            writes_seen,
  output int            lba48_reqs,
  output int            lba28_reqs,
  output int            chs_reqs
);
  import atb_pkg::*;

  localparam logic OP_WRITE = 1'b1;

  localparam logic [47:0] LBA48_START  = 48'h1000_0000;
  localparam int unsigned TRACK_SECTS  = 63;
  localparam int unsigned TRACK_HEADS  = 16;
  localparam int unsigned SECTOR_SIZE  = 512;

  typedef enum logic [1:0] {MODE_CHS, MODE_LBA28, MODE_LBA48} addr_mode_t;

  wr_t  taskfile_writes_due[$];
  logic lba_en;
  logic slave_en;

  initial begin
    errors         = 0;
    pending_writes = 0;
    writes_seen    = 0;
    lba48_reqs     = 0;
    lba28_reqs     = 0;
    chs_reqs       = 0;
    lba_en         = 1'b0;
    slave_en       = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h (write %0d)",
             $time, what, got, want, writes_seen);
    errors++;
  endtask

  function automatic void queue_write(input logic [2:0] off, input logic [7:0] val,
                                      input logic last);
    wr_t w;
    w.reg_offset = off;
    w.reg_value  = val;
    w.last_write = last;
    taskfile_writes_due = {taskfile_writes_due, w};
  endfunction

  // Build the register write sequence one request sets up.
  function automatic addr_mode_t plan_taskfile(input req_t r, input logic lba_on,
                                               input logic slave_on);
    logic [31:0] sectors;
    logic [31:0] a;
    logic [31:0] track;
    logic [31:0] cyl;
    logic [7:0]  count;
    logic [7:0]  dsel;
    logic [7:0]  cmd;
    logic [7:0]  lo0;
    logic [7:0]  lo1;
    logic [7:0]  lo2;
    logic [3:0]  head;
    addr_mode_t  mode;

    sectors = r.buffer_bytes / SECTOR_SIZE;
    count   = (sectors > 32'(MAX_COUNT)) ? MAX_COUNT : sectors[7:0];
    a       = r.block_address[31:0];
    dsel    = DSEL_BASE;

    if (r.block_address >= LBA48_START) begin
      mode = MODE_LBA48;
      head = 4'h0;
      dsel |= DSEL_LBA;
      lo0  = a[7:0];
      lo1  = a[15:8];
      lo2  = a[23:16];
    end else if (lba_on) begin
      mode = MODE_LBA28;
      head = a[27:24];
      dsel |= DSEL_LBA;
      lo0  = a[7:0];
      lo1  = a[15:8];
      lo2  = a[23:16];
    end else begin
      mode  = MODE_CHS;
      track = a / TRACK_SECTS;
      // cylinder keeps only its low 16 bits
      cyl   = track / TRACK_HEADS;
      lo0   = 8'(a % TRACK_SECTS + 1);
      lo1   = cyl[7:0];
      lo2   = cyl[15:8];
      head  = track[3:0];
    end

    if (slave_on) dsel |= DSEL_SLAVE;
    dsel |= {4'h0, head};

    if (r.op == OP_WRITE) cmd = (mode == MODE_LBA48) ? CMD_WRITE_EXT : CMD_WRITE;
    else                  cmd = (mode == MODE_LBA48) ? CMD_READ_EXT : CMD_READ;

    queue_write(REG_DSEL, dsel, 1'b0);
    if (mode == MODE_LBA48) begin
      queue_write(REG_COUNT, 8'h00, 1'b0);
      queue_write(REG_LBA0, r.block_address[31:24], 1'b0);
      queue_write(REG_LBA1, r.block_address[39:32], 1'b0);
      queue_write(REG_LBA2, r.block_address[47:40], 1'b0);
    end
    queue_write(REG_COUNT, count, 1'b0);
    queue_write(REG_LBA0, lo0, 1'b0);
    queue_write(REG_LBA1, lo1, 1'b0);
    queue_write(REG_LBA2, lo2, 1'b0);
    queue_write(REG_CMD, cmd, 1'b1);
    return mode;
  endfunction

  task automatic check_write(input wr_t got);
    wr_t want;
    if (taskfile_writes_due.size() == 0) begin
      report_mismatch("write with no request behind it", got, 0);
    end else begin
      want = taskfile_writes_due.pop_front();
      if (got.reg_offset !== want.reg_offset)
        report_mismatch("reg_offset", got.reg_offset, want.reg_offset);
      if (got.reg_value !== want.reg_value)
        report_mismatch("reg_value", got.reg_value, want.reg_value);
      if (got.last_write !== want.last_write)
        report_mismatch("last_write", got.last_write, want.last_write);
    end
    writes_seen++;
  endtask

  always @(posedge clk) begin
    logic [2:0] cfg_index;
    addr_mode_t mode;
    if (rst) begin
      lba_en   = 1'b0;
      slave_en = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        cfg_index = paddr >> 2;
        if (cfg_index == 3'(CFG_LBA_SUPPORTED)) lba_en = pwdata[0];
        else if (cfg_index == 3'(CFG_SLAVE_DRIVE)) slave_en = pwdata[0];
      end
      if (out_valid && out_ready) check_write(out_data);
      if (in_valid && in_ready) begin
        mode = plan_taskfile(in_data, lba_en, slave_en);
        case (mode)
          MODE_LBA48: lba48_reqs++;
          MODE_LBA28: lba28_reqs++;
          default:    chs_reqs++;
        endcase
      end
    end
    pending_writes = taskfile_writes_due.size();
  end

endmodule

### tb/sv/ata_pio_taskfile_builder_top_tb.sv
`timescale 1ns / 100ps

module ata_pio_taskfile_builder_top_tb;
  import atb_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int LONG_HOLD     = 400;
  localparam int DIRECTED_REQS = 13;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  req_t        in_data;
  logic        out_valid;
  logic        out_ready;
  wr_t         out_data;

  int errors;
  int pending_writes;
  int writes_seen;
  int lba48_reqs;
  int lba28_reqs;
  int chs_reqs;

  int send_idle;
  int recv_idle;
  bit long_hold_req;

  ata_pio_taskfile_builder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ata_pio_taskfile_builder_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .errors         (errors),
    .pending_writes (pending_writes),
    .writes_seen    (writes_seen),
    .lba48_reqs     (lba48_reqs),
    .lba28_reqs     (lba28_reqs),
    .chs_reqs       (chs_reqs)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("timeout with %0d writes still expected", pending_writes);
    $display("DONE: errors detected");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic lba_on, input logic slave_on);
    cfg_write(CFG_LBA_SUPPORTED, lba_on);
    cfg_write(CFG_SLAVE_DRIVE, slave_on);
  endtask

  // Wait for every expected write, then let the pipeline go quiet.
  task automatic settle();
    int guard;
    guard = 0;
    @(posedge clk);
    while (pending_writes != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_request(input req_t r);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic req_t directed_request(input int idx);
    req_t r;
    r.op = idx[0];
    case (idx)
      0:       begin r.block_address = 48'd0;                r.buffer_bytes = 32'd0;          end
      1:       begin r.block_address = 48'd0;                r.buffer_bytes = 32'hFFFF_FFFF;  end
      2:       begin r.block_address = 48'd62;               r.buffer_bytes = 32'd511;        end
      3:       begin r.block_address = 48'd63;               r.buffer_bytes = 32'd512;        end
      4:       begin r.block_address = 48'd1007;             r.buffer_bytes = 32'd130560;     end
      5:       begin r.block_address = 48'd1008;             r.buffer_bytes = 32'd131071;     end
      6:       begin r.block_address = 48'h0FFF_FFFF;        r.buffer_bytes = 32'd131072;     end
      7:       begin r.block_address = 48'h1000_0000;        r.buffer_bytes = 32'd1024;       end
      8:       begin r.block_address = 48'hFFFF_FFFF_FFFF;   r.buffer_bytes = 32'h8000_0000;  end
      9:       begin r.block_address = 48'hAAAA_AAAA_AAAA;   r.buffer_bytes = 32'h5555_5555;  end
      10:      begin r.block_address = 48'h5555_5555_5555;   r.buffer_bytes = 32'hAAAA_AAAA;  end
      11:      begin r.block_address = 48'h0555_5555;        r.buffer_bytes = 32'd102400;     end
      // first address whose cylinder wraps to zero
      default: begin r.block_address = 48'd66060288;         r.buffer_bytes = 32'd512;        end
    endcase
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.op = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.block_address = {16'($urandom), $urandom};
      if (r.block_address[47:28] == 20'h0) r.block_address[28 + $urandom_range(19)] = 1'b1;
    end else if (pick < 65) begin
      r.block_address = 48'($urandom_range(32'h0FFF_FFFF));
    end else if (pick < 75) begin
      r.block_address = 48'h0FFF_FFF8 + 48'($urandom_range(15));
    end else if (pick < 85) begin
      r.block_address = 48'($urandom_range(2100));
    end else if (pick < 92) begin
      r.block_address = 48'd66060284 + 48'($urandom_range(8));
    end else begin
      r.block_address = {16'($urandom), $urandom};
    end
    pick = $urandom_range(99);
    if (pick < 40)      r.buffer_bytes = $urandom_range(140000);
    else if (pick < 60) r.buffer_bytes = 32'(512 * $urandom_range(260)) - 1 + $urandom_range(2);
    else if (pick < 85) r.buffer_bytes = $urandom;
    else if (pick < 92) r.buffer_bytes = 32'd0;
    else                r.buffer_bytes = 32'hFFFF_FFFF;
    return r;
  endfunction

  task automatic run_directed();
    for (int i = 0; i < DIRECTED_REQS; i++) send_request(directed_request(i));
    in_valid <= 1'b0;
  endtask

  task automatic run_random(input int n);
    repeat (n) send_request(random_request());
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    send_idle = 37;
    recv_idle = 77;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_settings(1'b0, 1'b0);
    run_directed();
    settle();
    apply_settings(1'b1, 1'b1);
    run_directed();
    settle();

    // hold the output off long enough for the block to back up its input
    apply_settings(1'b1, 1'b0);
    long_hold_req = 1'b1;
    run_random(60);
    settle();

    send_idle = 77;
    recv_idle = 37;
    apply_settings(1'b0, 1'b1);
    run_random(60);
    settle();

    send_idle = 0;
    recv_idle = 0;
    apply_settings(1'b1, 1'b1);
    run_random(30);
    settle();
    apply_settings(1'b0, 1'b0);
    run_random(30);
    settle();

    if (pending_writes != 0)
      $display("%0d expected writes never arrived", pending_writes);
    $display("covered %0d requests: %0d LBA48, %0d LBA28, %0d CHS; %0d writes compared",
             lba48_reqs + lba28_reqs + chs_reqs, lba48_reqs, lba28_reqs, chs_reqs,
             writes_seen);
    $display("all four drive settings, three back-pressure mixes and one long output stall");
    if (errors == 0 && pending_writes == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
